// File: rtl/ctfc_pkg.sv
// Package for the CRC-16 trailer file checker: payload structs, codes,
// constants and the byte-wide reflected CRC step. No dependencies.
package ctfc_pkg;

	localparam int unsigned TRAILER_LENGTH = 12;
	localparam int unsigned COUNT_W        = 31;

	localparam logic [15:0] CRC_START = 16'hFBEA;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Trailer tag, in file order
	localparam logic [7:0] TAG_C = 8'h43;
	localparam logic [7:0] TAG_R = 8'h52;
	localparam logic [7:0] TAG_F = 8'h46;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_MODE  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STRICT_MODE = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_REJECT     = 2'd0,
		VERDICT_ACCEPT     = 2'd1,
		VERDICT_BAD_LENGTH = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       no_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         verdict;
		logic               has_trailer;
		logic [COUNT_W-1:0] payload_length;
		logic [31:0]        file_crc_word;
		logic [15:0]        payload_crc;
	} out_item_t;

	// File state after the current transaction's byte has been taken in
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               overlong;
		logic [15:0]        crc_trailer;  // CRC lagging TRAILER_LENGTH bytes
		logic [15:0]        crc_tail2;    // CRC lagging two bytes
		logic [31:0]        head4;        // oldest four held bytes, LSB first
		logic [31:0]        last4;        // newest four held bytes, LSB first
	} file_snap_t;

	// One byte through the reflected CRC-16
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/ctfc_file_state.sv
// Running file state: byte count, the two lagging CRCs and the tail delay line.
// Depends on ctfc_pkg.
module ctfc_file_state import ctfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_item_t   item,
	output file_snap_t snap
);

	logic [COUNT_W-1:0] count_q;
	logic               overlong_q;
	logic [15:0]        crc_trailer_q;
	logic [15:0]        crc_tail2_q;
	logic [7:0]         tail_q [TRAILER_LENGTH];

	logic               take_byte;
	logic               at_max;
	logic [COUNT_W-1:0] count_nx;
	logic               overlong_nx;
	logic [15:0]        crc_trailer_nx;
	logic [15:0]        crc_tail2_nx;
	logic [7:0]         tail_nx [TRAILER_LENGTH];

	assign take_byte = step && !item.no_data;
	assign at_max    = (count_q == COUNT_MAX);

	// Advance the count and CRCs with the byte that leaves each lag window
	always_comb begin
		count_nx       = count_q;
		overlong_nx    = overlong_q;
		crc_trailer_nx = crc_trailer_q;
		crc_tail2_nx   = crc_tail2_q;
		for (int i = 0; i < TRAILER_LENGTH; i++) begin
			tail_nx[i] = tail_q[i];
		end
		if (take_byte) begin
			if (count_q >= COUNT_W'(TRAILER_LENGTH)) begin
				crc_trailer_nx = crc16_byte(crc_trailer_q, tail_q[0]);
			end
			if (count_q >= COUNT_W'(2)) begin
				crc_tail2_nx = crc16_byte(crc_tail2_q, tail_q[TRAILER_LENGTH-2]);
			end
			for (int i = 0; i < TRAILER_LENGTH - 1; i++) begin
				tail_nx[i] = tail_q[i+1];
			end
			tail_nx[TRAILER_LENGTH-1] = item.data_byte;
			if (at_max) begin
				overlong_nx = 1'b1;
			end else begin
				count_nx = count_q + COUNT_W'(1);
			end
		end
	end

	assign snap.count       = count_nx;
	assign snap.overlong    = overlong_nx;
	assign snap.crc_trailer = crc_trailer_nx;
	assign snap.crc_tail2   = crc_tail2_nx;
	assign snap.head4       = {tail_nx[3], tail_nx[2], tail_nx[1], tail_nx[0]};
	assign snap.last4       = {tail_nx[TRAILER_LENGTH-1], tail_nx[TRAILER_LENGTH-2],
		tail_nx[TRAILER_LENGTH-3], tail_nx[TRAILER_LENGTH-4]};

	// Hold file control state; drop it back to start at file end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			overlong_q    <= 1'b0;
			crc_trailer_q <= CRC_START;
			crc_tail2_q   <= CRC_START;
		end else if (step) begin
			if (item.last_byte) begin
				count_q       <= '0;
				overlong_q    <= 1'b0;
				crc_trailer_q <= CRC_START;
				crc_tail2_q   <= CRC_START;
			end else begin
				count_q       <= count_nx;
				overlong_q    <= overlong_nx;
				crc_trailer_q <= crc_trailer_nx;
				crc_tail2_q   <= crc_tail2_nx;
			end
		end
	end

	// Tail delay line; entries are read only once written in the current file
	always_ff @(posedge clk) begin
		if (take_byte) begin
			for (int i = 0; i < TRAILER_LENGTH; i++) begin
				tail_q[i] <= tail_nx[i];
			end
		end
	end

endmodule

// File: rtl/ctfc_judge.sv
// End-of-file decision: trailer search, checksum compare and length checks.
// Depends on ctfc_pkg.
module ctfc_judge import ctfc_pkg::*; (
	input  file_snap_t snap,
	input  logic       check_mode,
	input  logic       strict_mode,
	output out_item_t  result
);

	logic tag_found;

	assign tag_found = (snap.count >= COUNT_W'(TRAILER_LENGTH))
		&& (snap.head4[7:0] == TAG_C) && (snap.head4[15:8] == TAG_R)
		&& (snap.head4[23:16] == TAG_C) && (snap.head4[31:24] == TAG_F);

	// Pick the verdict; every field stays zero unless the case sets it
	always_comb begin
		result = '0;
		if (snap.overlong) begin
			result.verdict = VERDICT_BAD_LENGTH;
		end else if (check_mode) begin
			if (snap.count < COUNT_W'(2)) begin
				result.verdict = VERDICT_BAD_LENGTH;
			end else begin
				result.payload_length = snap.count;
				result.verdict = (snap.crc_tail2 == snap.last4[31:16]) ?
					VERDICT_ACCEPT : VERDICT_REJECT;
			end
		end else if (tag_found) begin
			result.has_trailer    = 1'b1;
			result.payload_length = snap.count - COUNT_W'(TRAILER_LENGTH);
			result.file_crc_word  = snap.last4;
			result.payload_crc    = snap.crc_trailer;
			result.verdict = ({16'h0000, snap.crc_trailer} == snap.last4) ?
				VERDICT_ACCEPT : VERDICT_REJECT;
		end else begin
			result.payload_length = snap.count;
			result.verdict = strict_mode ? VERDICT_REJECT : VERDICT_ACCEPT;
		end
	end

endmodule

// File: rtl/crc16_trailer_file_check_top.sv
// Top level: input register, file state, decision logic and result register.
// Depends on ctfc_pkg, ctfc_file_state and ctfc_judge.
// A result is registered from a last transaction held in the input register.
// Throughput: one transaction per cycle; the single result register only holds
// back a last transaction while an earlier result is stalled.
// Reset: arst_n clears valid and config registers to zero, file state to its start.
module crc16_trailer_file_check_top import ctfc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic                   cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	logic       check_mode_q;
	logic       strict_mode_q;
	logic       valid_s1;
	in_item_t   item_s1;
	logic       out_valid_q;
	out_item_t  out_data_q;
	logic       in_accept;
	logic       proc;
	logic       proc_last;
	file_snap_t snap;
	out_item_t  result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_mode_q  <= 1'b0;
			strict_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHECK_MODE:  check_mode_q  <= cfg_data;
				CFG_STRICT_MODE: strict_mode_q <= cfg_data;
			endcase
		end
	end

	// A held transaction advances unless it would overwrite a stalled result
	assign proc      = valid_s1 && (!item_s1.last_byte || !out_valid_q || !out_stall);
	assign proc_last = proc && item_s1.last_byte;
	assign in_stall  = valid_s1 && !proc;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_data;
		end
	end

	ctfc_file_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (proc),
		.item   (item_s1),
		.snap   (snap)
	);

	ctfc_judge u_judge (
		.snap        (snap),
		.check_mode  (check_mode_q),
		.strict_mode (strict_mode_q),
		.result      (result)
	);

	// Result register: load on file end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_last) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A new result only follows a processed last transaction
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(proc_last))
		else $error("result appeared without a last transaction");

	// Stall input only while a transaction is held
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// Invalid length clears every other field
	a_bad_length_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.verdict == VERDICT_BAD_LENGTH) |->
		(!out_data_q.has_trailer && out_data_q.payload_length == '0
		&& out_data_q.file_crc_word == '0 && out_data_q.payload_crc == '0))
		else $error("invalid-length result carries nonzero fields");

	// A found trailer never pairs with an invalid length
	a_trailer_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.has_trailer) |->
		(out_data_q.verdict != VERDICT_BAD_LENGTH))
		else $error("trailer reported with invalid length");

endmodule
